// ===== hw/rtl/mm_pkg.sv =====
// Shared types, constants and helpers for the matrix multiply block.
package mm_pkg;

   // Store geometry
   localparam int MAX_DIM = 8;
   localparam int IDX_W   = $clog2(MAX_DIM);
   localparam int ADDR_W  = 2 * IDX_W;
   localparam int DEPTH   = MAX_DIM * MAX_DIM;

   // Field widths
   localparam int DIM_W     = 4;
   localparam int VALUE_W   = 16;
   localparam int MUL_W     = 2 * VALUE_W;
   localparam int PROD_W    = 35;
   localparam int CSR_IDX_W = 2;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ROWS_A    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INNER_DIM = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COLS_B    = 2'd2;

   localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(MAX_DIM);

   typedef enum logic [1:0] {
      ACT_LOAD_A  = 2'd0,
      ACT_LOAD_B  = 2'd1,
      ACT_COMPUTE = 2'd2
   } action_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DRAIN
   } state_type;

   typedef struct packed {
      action_type                 action;
      logic [2:0]                 row;
      logic [2:0]                 col;
      logic signed [VALUE_W-1:0]  value;
   } req_type;

   typedef struct packed {
      logic signed [PROD_W-1:0]   product;
      logic [2:0]                 out_row;
      logic [2:0]                 out_col;
      logic                       last;
   } rsp_type;

   // One multiply-accumulate step as it moves down the pipe
   typedef struct packed {
      logic             valid;
      logic             first;   // first term of a dot product
      logic             last_k;  // final term of a dot product
      logic             last;    // final element of the run
      logic [IDX_W-1:0] row;
      logic [IDX_W-1:0] col;
   } beat_type;

   // Store port control from the sequencer
   typedef struct packed {
      logic              wr_a;
      logic              wr_b;
      logic [ADDR_W-1:0] wr_addr;
      logic [ADDR_W-1:0] rd_addr_a;
      logic [ADDR_W-1:0] rd_addr_b;
   } store_ctl_type;

   // Zero counts as one, anything above the store size as the store size
   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
      logic [DIM_W-1:0] res;
      res = v;
      if (v == '0) begin
         res = DIM_W'(1);
      end else if (v > DIM_W'(MAX_DIM)) begin
         res = DIM_W'(MAX_DIM);
      end
      return res;
   endfunction

endpackage

// ===== hw/rtl/matrix_multiply.sv =====
// Top level of the matrix multiply block.
//
// Usage: req_ carries items. A load item (action load A or load B) writes
// one Q4.12 element at (row, col) into the A or B store. A compute item
// makes the block emit, on rsp_, every element of C = A * B in row-major
// order as an exact Q11.24 dot product; the final one has last. Dimensions
// come from the csr_ write port (rows_a, inner_dim, cols_b). A compute item
// runs rows_a * cols_b * inner_dim multiply-accumulate terms through the
// single multiply-accumulate unit, then drains the pipe; each element of C
// is sent once its last term is summed. req_stall is high for the whole
// run; a following item is taken while the last result still waits.
// While the receiver holds rsp_stall with a result pending, the whole
// multiply pipe freezes and resumes without loss.
// Reset clears control state and sets all dimensions to 8; the element
// stores hold no defined value until loaded, and no clearing pass runs.
module matrix_multiply (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  mm_pkg::req_type               req,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output mm_pkg::rsp_type               rsp,
   input  logic                          csr_we,
   input  logic [mm_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [mm_pkg::DIM_W-1:0]      csr_wdata
);
   import mm_pkg::*;

   beat_type                  beat;
   store_ctl_type             ctl;
   logic                      adv, pipe_busy;
   logic signed [VALUE_W-1:0] a_data, b_data;

   mm_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req       (req),
      .req_stall (req_stall),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .adv       (adv),
      .pipe_busy (pipe_busy),
      .beat      (beat),
      .ctl       (ctl)
   );

   mm_stores u_stores (
      .clock   (clock),
      .ctl     (ctl),
      .wr_data (req.value),
      .rd_en   (adv),
      .a_data  (a_data),
      .b_data  (b_data)
   );

   mm_mac u_mac (
      .clock     (clock),
      .reset     (reset),
      .beat      (beat),
      .a_data    (a_data),
      .b_data    (b_data),
      .adv       (adv),
      .pipe_busy (pipe_busy),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp       (rsp)
   );

   // A compute item closes the intake on the next cycle
   a_compute_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req.action == ACT_COMPUTE |=> req_stall)
      else $error("intake open after compute item");

   // Intake only reopens once the multiply pipe is empty
   a_idle_empty: assert property (@(posedge clock) disable iff (reset)
      !req_stall |-> !pipe_busy)
      else $error("intake open with work in the pipe");

   // The intake closes only because a compute item was taken
   a_busy_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(req_stall) |-> $past(req_valid && req.action == ACT_COMPUTE))
      else $error("intake closed without a compute item");

endmodule

// ===== hw/rtl/mm_stores.sv =====
// Element stores for matrix A and matrix B, one write and one read port each.
module mm_stores (
   input  logic                                 clock,
   input  mm_pkg::store_ctl_type                ctl,
   input  logic signed [mm_pkg::VALUE_W-1:0]    wr_data,
   input  logic                                 rd_en,
   output logic signed [mm_pkg::VALUE_W-1:0]    a_data,
   output logic signed [mm_pkg::VALUE_W-1:0]    b_data
);
   import mm_pkg::*;

   logic [VALUE_W-1:0] store_a_ff [DEPTH];
   logic [VALUE_W-1:0] store_b_ff [DEPTH];
   logic [VALUE_W-1:0] a_rd_ff;
   logic [VALUE_W-1:0] b_rd_ff;

   // Loads
   always_ff @(posedge clock) begin
      if (ctl.wr_a) begin
         store_a_ff[ctl.wr_addr] <= wr_data;
      end
      if (ctl.wr_b) begin
         store_b_ff[ctl.wr_addr] <= wr_data;
      end
   end

   // Registered reads, held while the pipe is frozen
   always_ff @(posedge clock) begin
      if (rd_en) begin
         a_rd_ff <= store_a_ff[ctl.rd_addr_a];
         b_rd_ff <= store_b_ff[ctl.rd_addr_b];
      end
   end

   assign a_data = signed'(a_rd_ff);
   assign b_data = signed'(b_rd_ff);

endmodule

// ===== hw/rtl/mm_seq.sv =====
// Sequencer: dimension registers, item intake and the row/column/term counters.
module mm_seq (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   input  mm_pkg::req_type                  req,
   output logic                             req_stall,
   input  logic                             csr_we,
   input  logic [mm_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [mm_pkg::DIM_W-1:0]         csr_wdata,
   input  logic                             adv,
   input  logic                             pipe_busy,
   output mm_pkg::beat_type                 beat,
   output mm_pkg::store_ctl_type            ctl
);
   import mm_pkg::*;

   state_type        state_ff, state_in;
   logic [DIM_W-1:0] rows_a_ff, inner_dim_ff, cols_b_ff;
   logic [DIM_W-1:0] nr_ff, nk_ff, nc_ff;
   logic [DIM_W-1:0] nr_in, nk_in, nc_in;
   logic [IDX_W-1:0] r_ff, c_ff, k_ff;
   logic [IDX_W-1:0] r_in, c_in, k_in;
   logic             accept, start;
   logic             r_last, c_last, k_last;

   assign accept = req_valid && !req_stall;
   assign start  = accept && (req.action == ACT_COMPUTE);

   assign r_last = (r_ff == IDX_W'(nr_ff - DIM_W'(1)));
   assign c_last = (c_ff == IDX_W'(nc_ff - DIM_W'(1)));
   assign k_last = (k_ff == IDX_W'(nk_ff - DIM_W'(1)));

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rows_a_ff    <= DIM_RESET;
         inner_dim_ff <= DIM_RESET;
         cols_b_ff    <= DIM_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_ROWS_A:    rows_a_ff    <= csr_wdata;
            CSR_INNER_DIM: inner_dim_ff <= csr_wdata;
            CSR_COLS_B:    cols_b_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Counters: term innermost, then column, then row
   always_comb begin
      nr_in = nr_ff;
      nk_in = nk_ff;
      nc_in = nc_ff;
      r_in  = r_ff;
      c_in  = c_ff;
      k_in  = k_ff;
      if (start) begin
         nr_in = clamp_dim(rows_a_ff);
         nk_in = clamp_dim(inner_dim_ff);
         nc_in = clamp_dim(cols_b_ff);
         r_in  = '0;
         c_in  = '0;
         k_in  = '0;
      end else if (state_ff == ST_RUN && adv) begin
         if (k_last) begin
            k_in = '0;
            if (c_last) begin
               c_in = '0;
               r_in = r_ff + IDX_W'(1);
            end else begin
               c_in = c_ff + IDX_W'(1);
            end
         end else begin
            k_in = k_ff + IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      nr_ff <= nr_in;
      nk_ff <= nk_in;
      nc_ff <= nc_in;
      r_ff  <= r_in;
      c_ff  <= c_in;
      k_ff  <= k_in;
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (adv && r_last && c_last && k_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!pipe_busy) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Outputs
   always_comb begin
      req_stall     = (state_ff != ST_IDLE);
      beat.valid    = (state_ff == ST_RUN);
      beat.first    = (k_ff == '0);
      beat.last_k   = k_last;
      beat.last     = r_last && c_last;
      beat.row      = r_ff;
      beat.col      = c_ff;
      ctl.wr_a      = accept && (req.action == ACT_LOAD_A);
      ctl.wr_b      = accept && (req.action == ACT_LOAD_B);
      ctl.wr_addr   = {IDX_W'(req.row), IDX_W'(req.col)};
      ctl.rd_addr_a = {r_ff, k_ff};
      ctl.rd_addr_b = {k_ff, c_ff};
   end

endmodule

// ===== hw/rtl/mm_mac.sv =====
// Shared multiply-accumulate unit and result register.
module mm_mac (
   input  logic                                 clock,
   input  logic                                 reset,
   input  mm_pkg::beat_type                     beat,
   input  logic signed [mm_pkg::VALUE_W-1:0]    a_data,
   input  logic signed [mm_pkg::VALUE_W-1:0]    b_data,
   output logic                                 adv,
   output logic                                 pipe_busy,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output mm_pkg::rsp_type                      rsp
);
   import mm_pkg::*;

   beat_type                 beat_s1_ff, beat_s2_ff;
   logic signed [MUL_W-1:0]  mul_ff;
   logic signed [PROD_W-1:0] acc_ff, acc_in;
   rsp_type                  rsp_ff;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     finish;

   // Whole pipe freezes while a finished item waits on a stalled receiver
   assign adv       = !(rsp_valid_ff && rsp_stall);
   assign pipe_busy = beat_s1_ff.valid || beat_s2_ff.valid;
   assign finish    = adv && beat_s2_ff.valid && beat_s2_ff.last_k;

   assign acc_in = beat_s2_ff.first ? PROD_W'(mul_ff) : acc_ff + PROD_W'(mul_ff);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Step flags
   always_ff @(posedge clock) begin
      if (reset) begin
         beat_s1_ff   <= '0;
         beat_s2_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (adv) begin
            beat_s1_ff <= beat;
            beat_s2_ff <= beat_s1_ff;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Multiply, accumulate, result payload
   always_ff @(posedge clock) begin
      if (adv) begin
         mul_ff <= a_data * b_data;
         if (beat_s2_ff.valid) begin
            acc_ff <= acc_in;
         end
      end
      if (finish) begin
         rsp_ff.product <= acc_in;
         rsp_ff.out_row <= 3'(beat_s2_ff.row);
         rsp_ff.out_col <= 3'(beat_s2_ff.col);
         rsp_ff.last    <= beat_s2_ff.last;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule
